FILE: hdl/clcd_pkg.sv
// Package for the character LCD nibble writer.
// Holds payload and job types, action codes, command constants and the address helper.
package clcd_pkg;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_GOTO  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] ROW_STRIDE   = 8'h40;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] NEWLINE      = 8'd10;
  localparam logic [7:0] HIGH_MASK    = 8'b1111_0000;
  localparam logic [7:0] LOW_MASK     = 8'b0000_1111;

  localparam int COL_W   = 5;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] character;
    logic [7:0] goto_column;
    logic [7:0] goto_row;
  } item_t;

  typedef struct packed {
    logic       register_select;
    logic [3:0] nibble;
    logic       transfer;
    logic       goto_error;
    logic       last;
  } result_t;

  // One classified item: a leading byte, an optional trailing data byte,
  // or the error marker alone.
  typedef struct packed {
    logic       err;
    logic       two_bytes;
    logic       rs0;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } job_t;

  function automatic logic [7:0] set_addr(input logic row, input logic [COL_W-1:0] col);
    set_addr = CMD_SET_ADDR | (row ? ROW_STRIDE : 8'h00) | {3'b000, col};
  endfunction

endpackage

FILE: hdl/clcd_front.sv
// Front end: accepts items, keeps the cursor and turns each item into a job; unused actions make none.
// Depends on clcd_pkg.
module clcd_front #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  clcd_pkg::item_t     item,
  input  logic                q_full,
  output logic                push,
  output clcd_pkg::job_t      job
);

  logic [clcd_pkg::COL_W-1:0] cursor_column, cursor_column_next;
  logic                       cursor_row, cursor_row_next;
  logic                       accept, past_end, goto_bad, row_inc, emit;

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;
  assign past_end   = cursor_column >= clcd_pkg::COL_W'(COLUMNS);
  assign goto_bad   = (item.goto_column >= 8'(COLUMNS)) || (item.goto_row >= 8'(ROWS));
  assign row_inc    = (ROWS > 1) ? ~cursor_row : 1'b0;
  assign push       = accept && emit;

  always_comb begin
    job                = '0;
    emit               = 1'b1;
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    unique case (item.action)
      clcd_pkg::ACT_WRITE: begin
        if (past_end) begin
          // wrap first, then the byte as data
          job.two_bytes      = 1'b1;
          job.byte0          = clcd_pkg::set_addr(row_inc, '0);
          job.byte1          = item.character;
          cursor_column_next = clcd_pkg::COL_W'(1);
          cursor_row_next    = row_inc;
        end else if (item.character == clcd_pkg::NEWLINE) begin
          job.byte0          = clcd_pkg::set_addr(row_inc, '0);
          cursor_column_next = '0;
          cursor_row_next    = row_inc;
        end else begin
          job.rs0            = 1'b1;
          job.byte0          = item.character;
          cursor_column_next = cursor_column + clcd_pkg::COL_W'(1);
        end
      end
      clcd_pkg::ACT_GOTO: begin
        if (goto_bad) begin
          job.err = 1'b1;
        end else begin
          job.byte0          = clcd_pkg::set_addr(item.goto_row[0],
                                                  item.goto_column[clcd_pkg::COL_W-1:0]);
          cursor_column_next = item.goto_column[clcd_pkg::COL_W-1:0];
          cursor_row_next    = item.goto_row[0];
        end
      end
      clcd_pkg::ACT_CLEAR: begin
        job.byte0          = clcd_pkg::CMD_CLEAR;
        cursor_column_next = '0;
        cursor_row_next    = 1'b0;
      end
      default: begin
        emit = 1'b0;  // unused action: dropped
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= 1'b0;
    end else if (accept) begin
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
    end
  end

endmodule

FILE: hdl/clcd_queue.sv
// Short job queue between front and back end.
// Depends on clcd_pkg.
module clcd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  clcd_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output clcd_pkg::job_t head
);

  clcd_pkg::job_t              mem [clcd_pkg::QDEPTH];
  logic [clcd_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [clcd_pkg::QCNT_W-1:0] count;
  logic                        do_pop;

  assign full       = count == clcd_pkg::QCNT_W'(clcd_pkg::QDEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/clcd_back.sv
// Back end: steps through the head job one nibble per cycle, unless result_stall holds it, into the result register.
// Depends on clcd_pkg.
module clcd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  clcd_pkg::job_t    head,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output clcd_pkg::result_t result
);

  logic [1:0]        idx;
  logic              load, is_last;
  logic [7:0]        cur_byte;
  clcd_pkg::result_t nxt;

  assign load     = head_valid && (!result_valid || !result_stall);
  assign is_last  = head.err || (head.two_bytes ? (idx == 2'd3) : (idx == 2'd1));
  assign pop      = load && is_last;
  assign cur_byte = idx[1] ? head.byte1 : head.byte0;

  always_comb begin
    nxt                 = '0;
    nxt.last            = is_last;
    if (head.err) begin
      nxt.goto_error    = 1'b1;
    end else begin
      nxt.transfer        = 1'b1;
      nxt.register_select = idx[1] ? 1'b1 : head.rs0;
      nxt.nibble          = idx[0] ? cur_byte[3:0] & clcd_pkg::LOW_MASK[3:0]
                                   : 4'((cur_byte & clcd_pkg::HIGH_MASK) >> 4);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        idx          <= is_last ? 2'd0 : idx + 2'd1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/char_lcd_cursor_nibble_writer.sv
// Top level of the character LCD nibble writer: front end, job queue, back end.
// Depends on clcd_pkg, clcd_front, clcd_queue, clcd_back.
//
//   channel  direction  handshake                  payload
//   item     in         item_valid / item_stall    clcd_pkg::item_t
//   result   out        result_valid / result_stall clcd_pkg::result_t
//
// The back end sends one nibble per cycle unless result_stall holds it: 2 nibbles for a plain character, goto,
// newline or clear, 4 for a character that wraps, and for a bad goto only the error result.
// The front end takes one item per cycle while the 2-entry job queue has room.
// Reset (synchronous) homes the cursor and empties the queue and result register.
// result_stall holds the result register; a full queue raises item_stall.
module char_lcd_cursor_nibble_writer #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  clcd_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output clcd_pkg::result_t result
);

  logic           q_full, push, pop, head_valid;
  clcd_pkg::job_t job, head;

  clcd_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .q_full    (q_full),
    .push      (push),
    .job       (job)
  );

  clcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (job),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  clcd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

FILE: hdl/clcd_checker.sv
// Port-level checks for the character LCD nibble writer, bound to the top level.
// Depends on clcd_pkg.
module clcd_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input clcd_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input clcd_pkg::result_t result
);

  // error result is a lone, empty, final item
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.goto_error |->
      !result.transfer && result.last && result.nibble == 4'd0 && !result.register_select)
    else $error("malformed goto error result");

  // only the error result skips the bus
  a_no_silent: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.transfer |-> result.goto_error)
    else $error("non-transfer result without error flag");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // a stalled input item is held by the sender
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("stalled input item changed");

  a_reset_clear: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind char_lcd_cursor_nibble_writer clcd_checker u_clcd_checker (.*);
